// File: hdl/hbdt_pkg.sv
// Shared constants, codes and types for the H-bridge PWM dead-time timer.
package hbdt_pkg;

  localparam int CHANNELS   = 8;
  localparam int PWM_PERIOD = 100;

  localparam int PHASE_W = (PWM_PERIOD > 1) ? $clog2(PWM_PERIOD) : 1;
  localparam int DUTY_W  = 7;
  localparam int CMP_W   = (PHASE_W > DUTY_W) ? PHASE_W : DUTY_W;
  localparam int DEAD_W  = 16;
  localparam int DELAY_W = 31;
  localparam int MS_W    = 32;
  localparam int PINS_W  = 16;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_DELAY = 2'd2;

  typedef struct packed {
    logic               tick;
    logic               phase_zero;
    logic [PHASE_W-1:0] phase;
    logic [DUTY_W-1:0]  duty;
    logic [1:0]         direction;
    logic [DEAD_W-1:0]  dead_time;
    logic               enable;
  } hbdt_ctl_t;

endpackage

// File: hdl/hbdt_chan.sv
// One H-bridge channel: duty, enable, direction, dead-time count and its pin pair.
module hbdt_chan (
  input  logic                clk,
  input  logic                rst,
  input  hbdt_pkg::hbdt_ctl_t ctl,
  input  logic                wr_sel,
  output logic [1:0]          pins_next
);
  import hbdt_pkg::*;

  logic [DEAD_W-1:0] dead_count, dead_count_next;
  logic [1:0]        live_dir, live_dir_next;
  logic [1:0]        pending_dir, pending_dir_next;
  logic [DUTY_W-1:0] duty_level, duty_level_next;
  logic              chan_enable, chan_enable_next;
  logic [1:0]        pins;

  always_comb begin
    dead_count_next  = dead_count;
    live_dir_next    = live_dir;
    pending_dir_next = pending_dir;
    duty_level_next  = duty_level;
    chan_enable_next = chan_enable;
    pins_next        = pins;
    if (ctl.tick) begin
      if (dead_count != '0) begin
        dead_count_next = dead_count - DEAD_W'(1);
        if (dead_count == DEAD_W'(1)) begin
          live_dir_next = pending_dir;
        end
      end
      if (ctl.phase_zero) begin
        if (chan_enable) begin
          pins_next = live_dir_next;
        end
      end else if (CMP_W'(duty_level) == CMP_W'(ctl.phase)) begin
        pins_next = 2'b00;
      end
    end else if (wr_sel) begin
      duty_level_next  = ctl.duty;
      chan_enable_next = ctl.enable;
      pending_dir_next = ctl.direction;
      dead_count_next  = ctl.dead_time;
      if (ctl.dead_time == '0) begin
        live_dir_next = ctl.direction;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_count  <= '0;
      live_dir    <= '0;
      pending_dir <= '0;
      duty_level  <= '0;
      chan_enable <= 1'b0;
      pins        <= '0;
    end else begin
      dead_count  <= dead_count_next;
      live_dir    <= live_dir_next;
      pending_dir <= pending_dir_next;
      duty_level  <= duty_level_next;
      chan_enable <= chan_enable_next;
      pins        <= pins_next;
    end
  end

endmodule

// File: hdl/pwm_hbridge_deadtime_timer_core.sv
// Top level of the eight-channel H-bridge software PWM with dead time.
// Every word on the slave side is a tick, a channel write or a delay load, and
// produces exactly one result word: the pin levels, the millisecond counter and
// the delay-active flag as they stand after that word. One word is taken per
// clock cycle while the result register can drain; a word held in the input
// register is applied to the channel states combinationally and its result
// appears on the master side on the next edge. The block keeps taking words
// while a result waits, as long as the result register can drain; throughput
// is one word per cycle under that condition.
module pwm_hbridge_deadtime_timer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // channel[2:0], duty[9:3], direction[11:10], dead_time[27:12], enable[28],
  // delay_value[59:29], zero fill [63:60]
  input  logic [63:0] s_tdata,
  // func[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pins[15:0], ms_time[47:16], delay_active[48], zero fill [55:49]
  output logic [55:0] m_tdata
);
  import hbdt_pkg::*;

  logic               in_valid;
  logic [1:0]         in_func;
  logic [2:0]         in_channel;
  logic [DUTY_W-1:0]  in_duty;
  logic [1:0]         in_direction;
  logic [DEAD_W-1:0]  in_dead_time;
  logic               in_enable;
  logic [DELAY_W-1:0] in_delay_value;

  logic               advance;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [PHASE_W:0]   phase_inc;
  logic [MS_W-1:0]    ms_counter, ms_counter_next;
  logic [DELAY_W-1:0] delay_count, delay_count_next;
  logic               do_tick;
  logic               do_write;
  hbdt_ctl_t          ctl;
  logic [PINS_W-1:0]  pins_next;
  logic [PINS_W-1:0]  out_pins;
  logic [MS_W-1:0]    out_ms;
  logic               out_delay;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign do_tick  = advance && (in_func == FUNC_TICK);
  assign do_write = advance && (in_func == FUNC_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func        <= s_tuser;
      in_channel     <= s_tdata[2:0];
      in_duty        <= s_tdata[9:3];
      in_direction   <= s_tdata[11:10];
      in_dead_time   <= s_tdata[27:12];
      in_enable      <= s_tdata[28];
      in_delay_value <= s_tdata[59:29];
    end
  end

  always_comb begin
    ctl.tick       = do_tick;
    ctl.phase_zero = (phase == '0);
    ctl.phase      = phase;
    ctl.duty       = in_duty;
    ctl.direction  = in_direction;
    ctl.dead_time  = in_dead_time;
    ctl.enable     = in_enable;
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    hbdt_chan u_chan (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr_sel    (do_write && (int'(in_channel) == c)),
      .pins_next (pins_next[2*c +: 2])
    );
  end

  if (2 * CHANNELS < PINS_W) begin : g_pin_fill
    assign pins_next[PINS_W-1:2*CHANNELS] = '0;
  end

  always_comb begin
    phase_inc        = {1'b0, phase} + (PHASE_W+1)'(1);
    phase_next       = phase;
    ms_counter_next  = ms_counter;
    delay_count_next = delay_count;
    if (do_tick) begin
      if (phase_inc >= (PHASE_W+1)'(PWM_PERIOD)) begin
        phase_next      = '0;
        ms_counter_next = ms_counter + MS_W'(1);
        if (delay_count != '0) begin
          delay_count_next = delay_count - DELAY_W'(1);
        end
      end else begin
        phase_next = phase_inc[PHASE_W-1:0];
      end
    end else if (advance && (in_func == FUNC_DELAY)) begin
      delay_count_next = in_delay_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      ms_counter  <= '0;
      delay_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      phase       <= phase_next;
      ms_counter  <= ms_counter_next;
      delay_count <= delay_count_next;
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pins  <= pins_next;
      out_ms    <= ms_counter_next;
      out_delay <= (delay_count_next != '0);
    end
  end

  assign m_tdata = {7'b0, out_delay, out_ms, out_pins};

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    32'(phase) < PWM_PERIOD)
    else $error("phase out of range");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without back-pressure");

  a_ms_on_wrap: assert property (@(posedge clk) disable iff (rst)
    (ms_counter != $past(ms_counter)) |-> ($past(do_tick) && phase == '0))
    else $error("millisecond counter moved without phase wrap");

  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    (!advance && !m_tvalid) |=> !m_tvalid)
    else $error("result appeared without an item");
`endif

endmodule

// File: bench/pwm_hbridge_deadtime_timer_core_test.sv
// Self-checking testbench for the H-bridge PWM dead-time timer core.
`timescale 1ns / 1ps

class pwm_scoreboard;
  logic [hbdt_pkg::PHASE_W-1:0] phase_now;
  logic [hbdt_pkg::MS_W-1:0]    ms_count;
  logic [hbdt_pkg::DELAY_W-1:0] delay_left;
  logic [hbdt_pkg::PINS_W-1:0]  pin_state;
  logic [hbdt_pkg::DEAD_W-1:0]  dead_left [hbdt_pkg::CHANNELS];
  logic [1:0]                   live_dir [hbdt_pkg::CHANNELS];
  logic [1:0]                   pending_dir [hbdt_pkg::CHANNELS];
  logic [hbdt_pkg::DUTY_W-1:0]  duty_set [hbdt_pkg::CHANNELS];
  logic                         enable_set [hbdt_pkg::CHANNELS];
  logic [55:0]                  expected_q [$];
  int                           failures;

  function new();
    phase_now  = '0;
    ms_count   = '0;
    delay_left = '0;
    pin_state  = '0;
    failures   = 0;
    for (int c = 0; c < hbdt_pkg::CHANNELS; c++) begin
      dead_left[c]   = '0;
      live_dir[c]    = '0;
      pending_dir[c] = '0;
      duty_set[c]    = '0;
      enable_set[c]  = 1'b0;
    end
  endfunction

  function void advance_tick();
    for (int c = 0; c < hbdt_pkg::CHANNELS; c++) begin
      if (dead_left[c] != 0) begin
        dead_left[c] = dead_left[c] - 1'b1;
        if (dead_left[c] == 0) live_dir[c] = pending_dir[c];
      end
    end
    for (int c = 0; c < hbdt_pkg::CHANNELS; c++) begin
      if (phase_now == 0) begin
        if (enable_set[c]) pin_state[2*c +: 2] = live_dir[c];
      end else if (duty_set[c] == phase_now) begin
        pin_state[2*c +: 2] = 2'b00;
      end
    end
    if (phase_now + 1 >= hbdt_pkg::PWM_PERIOD) begin
      phase_now = '0;
      ms_count  = ms_count + 1'b1;
      if (delay_left != 0) delay_left = delay_left - 1'b1;
    end else begin
      phase_now = phase_now + 1'b1;
    end
  endfunction

  function void note_word(logic [1:0] func, logic [63:0] data);
    logic [2:0] ch;
    ch = data[2:0];
    case (func)
      hbdt_pkg::FUNC_TICK: begin
        advance_tick();
      end
      hbdt_pkg::FUNC_WRITE: begin
        if (ch < hbdt_pkg::CHANNELS) begin
          duty_set[ch]    = data[9:3];
          pending_dir[ch] = data[11:10];
          dead_left[ch]   = data[27:12];
          enable_set[ch]  = data[28];
          if (data[27:12] == 0) live_dir[ch] = data[11:10];
        end
      end
      hbdt_pkg::FUNC_DELAY: begin
        delay_left = data[59:29];
      end
      default: begin
      end
    endcase
    expected_q.push_back({7'd0, (delay_left != 0), ms_count, pin_state});
  endfunction

  function void report(string what, logic [63:0] want, logic [63:0] got);
    failures++;
    if (failures <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  function void check_word(logic [55:0] got);
    logic [55:0] want;
    if (expected_q.size() == 0) begin
      report("unexpected result word", '0, 64'(got));
      return;
    end
    want = expected_q.pop_front();
    if (got[15:0] !== want[15:0]) report("pins", 64'(want[15:0]), 64'(got[15:0]));
    if (got[47:16] !== want[47:16]) report("ms_time", 64'(want[47:16]), 64'(got[47:16]));
    if (got[48] !== want[48]) report("delay_active", 64'(want[48]), 64'(got[48]));
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module pwm_hbridge_deadtime_timer_core_test;
  import hbdt_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  pwm_scoreboard sb = new();

  pwm_hbridge_deadtime_timer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("pwm_hbridge_deadtime_timer_core_test: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
    end
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [63:0] pack_word(logic [2:0] ch, logic [6:0] duty,
                                            logic [1:0] dir, logic [15:0] dead,
                                            logic en, logic [30:0] delay_val);
    return {4'd0, delay_val, en, dead, dir, duty, ch};
  endfunction

  task automatic send_word(input logic [1:0] func, input logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random_word();
    int          pick;
    logic [6:0]  duty;
    logic [15:0] dead;
    logic [30:0] delay_val;
    logic [63:0] noise;
    pick  = $urandom_range(99);
    noise = {$urandom(), $urandom()} & 64'h0FFF_FFFF_FFFF_FFFF;
    if (pick < 68) begin
      send_word(FUNC_TICK, noise);
    end else if (pick < 88) begin
      case ($urandom_range(4))
        0: duty = 7'd0;
        1: duty = 7'd1;
        2: duty = 7'd99;
        3: duty = 7'($urandom_range(1, 99));
        default: duty = 7'($urandom_range(127));
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4: dead = '0;
        9: dead = 16'($urandom());
        default: dead = 16'($urandom_range(1, 30));
      endcase
      send_word(FUNC_WRITE, pack_word(3'($urandom_range(7)), duty, 2'($urandom_range(3)),
                                      dead, ($urandom_range(9) != 0), 31'($urandom())));
    end else if (pick < 97) begin
      case ($urandom_range(9))
        0: delay_val = 31'($urandom());
        1, 2: delay_val = 31'($urandom_range(50));
        default: delay_val = 31'($urandom_range(3));
      endcase
      send_word(FUNC_DELAY, pack_word(3'($urandom()), 7'($urandom()), 2'($urandom()),
                                      16'($urandom()), 1'($urandom()), delay_val));
    end else begin
      send_word(FUNC_NONE, noise);
    end
  endtask

  initial begin
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    s_tuser        <= FUNC_TICK;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(FUNC_NONE, 64'h0FFF_FFFF_FFFF_FFFF);
    send_word(FUNC_WRITE, pack_word(3'd0, 7'd0, 2'd3, 16'd0, 1'b1, '0));
    send_word(FUNC_WRITE, pack_word(3'd1, 7'd100, 2'd2, 16'd0, 1'b1, '0));
    send_word(FUNC_WRITE, pack_word(3'd2, 7'd127, 2'd1, 16'd0, 1'b1, '1));
    send_word(FUNC_WRITE, pack_word(3'd3, 7'd1, 2'd3, 16'd0, 1'b1, '0));
    send_word(FUNC_WRITE, pack_word(3'd4, 7'd99, 2'd3, 16'd3, 1'b1, '0));
    send_word(FUNC_WRITE, pack_word(3'd5, 7'd50, 2'd3, 16'd0, 1'b0, '0));
    send_word(FUNC_WRITE, pack_word(3'd6, 7'd2, 2'd2, 16'd1, 1'b1, '0));
    send_word(FUNC_WRITE, pack_word(3'd7, 7'd2, 2'd3, 16'hFFFF, 1'b1, '0));
    send_word(FUNC_DELAY, pack_word('1, '1, '1, '1, 1'b1, 31'h7FFF_FFFF));
    send_word(FUNC_DELAY, pack_word('0, '0, '0, '0, 1'b0, 31'd1));
    repeat (12) send_word(FUNC_TICK, '0);
    send_word(FUNC_WRITE, pack_word(3'd0, 7'd3, 2'd1, 16'd2, 1'b1, '0));
    send_word(FUNC_NONE, '0);

    hold_left = 400;
    repeat (250) send_random_word();
    send_idle_pct = 58;
    repeat (250) send_random_word();
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    repeat (250) send_random_word();
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    repeat (250) send_random_word();

    s_tvalid       <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("pwm_hbridge_deadtime_timer_core_test: clean");
    end else begin
      $display("pwm_hbridge_deadtime_timer_core_test: errors");
    end
    $finish;
  end
endmodule
